FILE: rtl/nbgv_pkg.sv
// Package for the n-body velocity step core: register indexes, states, sizes.
package nbgv_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_INIT_VEL_X = 3'd0;
   localparam logic [2:0] CSR_INIT_VEL_Y = 3'd1;
   localparam logic [2:0] CSR_INIT_VEL_Z = 3'd2;
   localparam logic [2:0] CSR_TIME_STEP  = 3'd3;
   localparam logic [2:0] CSR_SPEED      = 3'd4;
   localparam logic [2:0] CSR_OWN_MASS   = 3'd5;

   localparam logic [23:0] TIME_STEP_RST = 24'd65536;
   localparam logic [23:0] SPEED_RST     = 24'd65536;
   localparam logic [31:0] OWN_MASS_RST  = 32'd256;

   // request kinds
   localparam logic KIND_VEL = 1'b0;
   localparam logic KIND_POS = 1'b1;

   localparam int            DIV_STEPS    = 91;   // numerator width
   localparam int            DIV_HI_STEPS = 44;   // steps that yield quotient bits >= 2^47
   localparam logic [5:0]    ROOT_TOP     = 6'd42;
   localparam logic [46:0]   INC_MAX      = {47{1'b1}};
   localparam logic [47:0]   VEL_MAX      = {1'b0, {47{1'b1}}};
   localparam logic [47:0]   VEL_MIN      = {1'b1, {47{1'b0}}};
   localparam logic [33:0]   STEP_CAP     = 34'h2_0000_0000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_SQ,
      ST_ROOT,
      ST_DEN,
      ST_NLOAD,
      ST_NUM,
      ST_DIV,
      ST_ACC,
      ST_PLOAD,
      ST_PMUL,
      ST_PADD,
      ST_OUT
   } state_type;

endpackage

FILE: rtl/nbody_gravity_velocity_step_core.sv
// Top level: serial fixed-point gravity accumulation and Euler position step for one body.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_tvalid/req_tready  | req_tdata, req_tuser, req_tlast
//  rsp     | out       | rsp_tvalid/rsp_tready  | rsp_tdata, rsp_tuser
//  csr     | in        | csr_we (no wait)       | csr_addr, csr_wdata
//
// A pair transaction normalizes the offsets, squares the three of them, takes the square
// root, forms r2*r with the shift-add multiplier, then per axis runs a shift-add multiply
// and a restoring divide of the 91-bit numerator. A position transaction runs a shift-add
// multiply per axis. Self pairs and skipped pairs go straight back to idle, or to the
// output state when flagged last. One transaction at a time; a new one is taken while
// a finished result waits in the output register.
// Reset is synchronous and needs no clearing pass.
module nbody_gravity_velocity_step_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // own_x, own_y, own_z, other_x, other_y, other_z, other_mass
   input  logic [223:0] req_tdata,
   // req_type, is_self
   input  logic [1:0]   req_tuser,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // vel_x, vel_y, vel_z, new_x, new_y, new_z
   output logic [239:0] rsp_tdata,
   // result_kind, fault
   output logic [1:0]   rsp_tuser,
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [47:0]  csr_wdata
);

   nbgv_pkg::state_type state_ff, state_in;

   logic        [1:0]  ax_ff, ax_in;
   logic               last_ff, last_in;
   logic               kind_ff, kind_in;
   logic        [47:0] vel_ff [3];
   logic        [47:0] vel_in [3];
   logic               fault_seen_ff, fault_seen_in;
   logic        [23:0] ts_ff, ts_in;
   logic        [23:0] ss_ff, ss_in;
   logic        [31:0] mass_ff, mass_in;
   logic        [31:0] pos_ff [3];
   logic        [31:0] pos_in [3];
   logic        [32:0] mg_ff [3];
   logic        [32:0] mg_in [3];
   logic        [2:0]  neg_ff, neg_in;
   logic        [3:0]  s_ff, s_in;
   logic        [41:0] r2_ff, r2_in;
   logic        [42:0] sqn_ff, sqn_in;
   logic        [42:0] sqr_ff, sqr_in;
   logic        [5:0]  sqb_ff, sqb_in;
   logic        [55:0] k_ff, k_in;
   logic        [47:0] tsss_ff, tsss_in;
   logic        [95:0] mc_ff, mc_in;
   logic        [47:0] mp_ff, mp_in;
   logic        [95:0] acc_ff, acc_in;
   logic        [88:0] dvs_ff, dvs_in;
   logic        [88:0] rem_ff, rem_in;
   logic        [90:0] num_ff, num_in;
   logic        [46:0] q_ff, q_in;
   logic               ovf_ff, ovf_in;
   logic        [6:0]  dcnt_ff, dcnt_in;
   logic        [31:0] npos_ff [3];
   logic        [31:0] npos_in [3];
   logic               rsp_valid_ff, rsp_valid_in;
   logic        [239:0] rsp_data_ff, rsp_data_in;
   logic        [1:0]  rsp_user_ff, rsp_user_in;

   logic               req_acc;
   logic               out_free;
   logic               mul_done;
   logic        [32:0] dif_w [3];
   logic        [31:0] own_w [3];
   logic               all_zero;
   logic               skip_pair;
   logic               big_w;

   assign req_acc  = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign mul_done = (mp_ff == '0);
   assign big_w    = (mg_ff[0][32:20] != '0) || (mg_ff[1][32:20] != '0)
                     || (mg_ff[2][32:20] != '0);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         own_w[i] = req_tdata[32*i +: 32];
         dif_w[i] = {req_tdata[96+32*i+31], req_tdata[96+32*i +: 32]}
                    - {own_w[i][31], own_w[i]};
      end
   end

   assign all_zero  = (dif_w[0] == '0) && (dif_w[1] == '0) && (dif_w[2] == '0);
   assign skip_pair = req_tuser[1] || (mass_ff == '0) || all_zero;

   assign req_tready = (state_ff == nbgv_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nbgv_pkg::ST_IDLE:
            if (req_acc) begin
               if (req_tuser[0] == nbgv_pkg::KIND_POS) begin
                  state_in = nbgv_pkg::ST_PLOAD;
               end else if (skip_pair) begin
                  state_in = req_tlast ? nbgv_pkg::ST_OUT : nbgv_pkg::ST_IDLE;
               end else begin
                  state_in = nbgv_pkg::ST_SHIFT;
               end
            end
         nbgv_pkg::ST_SHIFT: if (!big_w) state_in = nbgv_pkg::ST_SQ;
         nbgv_pkg::ST_SQ:    if (ax_ff == 2'd2) state_in = nbgv_pkg::ST_ROOT;
         nbgv_pkg::ST_ROOT:  if (sqb_ff == '0) state_in = nbgv_pkg::ST_DEN;
         nbgv_pkg::ST_DEN:   if (mul_done) state_in = nbgv_pkg::ST_NLOAD;
         nbgv_pkg::ST_NLOAD: state_in = nbgv_pkg::ST_NUM;
         nbgv_pkg::ST_NUM:   if (mul_done) state_in = nbgv_pkg::ST_DIV;
         nbgv_pkg::ST_DIV:
            if (dcnt_ff == 7'(nbgv_pkg::DIV_STEPS - 1)) state_in = nbgv_pkg::ST_ACC;
         nbgv_pkg::ST_ACC:
            if (ax_ff == 2'd2) begin
               state_in = last_ff ? nbgv_pkg::ST_OUT : nbgv_pkg::ST_IDLE;
            end else begin
               state_in = nbgv_pkg::ST_NLOAD;
            end
         nbgv_pkg::ST_PLOAD: state_in = nbgv_pkg::ST_PMUL;
         nbgv_pkg::ST_PMUL:  if (mul_done) state_in = nbgv_pkg::ST_PADD;
         nbgv_pkg::ST_PADD:
            state_in = (ax_ff == 2'd2) ? nbgv_pkg::ST_OUT : nbgv_pkg::ST_PLOAD;
         nbgv_pkg::ST_OUT:   if (out_free) state_in = nbgv_pkg::ST_IDLE;
         default:            state_in = nbgv_pkg::ST_IDLE;
      endcase
   end

   // datapath
   logic [39:0]  sq_w;
   logic [42:0]  bitv_w;
   logic [42:0]  trial_w;
   logic [24:0]  mg25_w;
   logic [89:0]  dtry_w;
   logic         dge_w;
   logic [89:0]  ddif_w;
   logic [46:0]  imag_w;
   logic [47:0]  inc_w;
   logic [48:0]  vsum_w;
   logic [47:0]  vabs_w;
   logic [55:0]  pprod_w;
   logic [33:0]  step_w;
   logic [34:0]  pos35_w;
   logic [34:0]  pnew_w;
   logic [47:0]  vcur_w;
   logic [32:0]  mcur_w;

   always_comb begin
      vcur_w  = vel_ff[ax_ff];
      mcur_w  = mg_ff[ax_ff];
      sq_w    = mcur_w[19:0] * mcur_w[19:0];
      bitv_w  = 43'd1 << sqb_ff;
      trial_w = sqr_ff + bitv_w;
      mg25_w  = {1'b0, mcur_w[19:0], 4'b0} + {2'b0, mcur_w[19:0], 3'b0}
                + {5'b0, mcur_w[19:0]};
      dtry_w  = {rem_ff, num_ff[90]};
      dge_w   = (dtry_w >= {1'b0, dvs_ff});
      ddif_w  = dtry_w - {1'b0, dvs_ff};
      imag_w  = ovf_ff ? nbgv_pkg::INC_MAX : q_ff;
      inc_w   = neg_ff[ax_ff] ? -{1'b0, imag_w} : {1'b0, imag_w};
      vsum_w  = {vcur_w[47], vcur_w} + {inc_w[47], inc_w};
      vabs_w  = vcur_w[47] ? -vcur_w : vcur_w;
      pprod_w = acc_ff[95:40];
      step_w  = (pprod_w > 56'(nbgv_pkg::STEP_CAP)) ? nbgv_pkg::STEP_CAP : pprod_w[33:0];
      pos35_w = {{3{pos_ff[ax_ff][31]}}, pos_ff[ax_ff]};
      pnew_w  = vcur_w[47] ? pos35_w - {1'b0, step_w} : pos35_w + {1'b0, step_w};
   end

   always_comb begin
      ax_in         = ax_ff;
      last_in       = last_ff;
      kind_in       = kind_ff;
      vel_in        = vel_ff;
      fault_seen_in = fault_seen_ff;
      ts_in         = ts_ff;
      ss_in         = ss_ff;
      mass_in       = mass_ff;
      pos_in        = pos_ff;
      mg_in         = mg_ff;
      neg_in        = neg_ff;
      s_in          = s_ff;
      r2_in         = r2_ff;
      sqn_in        = sqn_ff;
      sqr_in        = sqr_ff;
      sqb_in        = sqb_ff;
      k_in          = k_ff;
      tsss_in       = tsss_ff;
      mc_in         = mc_ff;
      mp_in         = mp_ff;
      acc_in        = acc_ff;
      dvs_in        = dvs_ff;
      rem_in        = rem_ff;
      num_in        = num_ff;
      q_in          = q_ff;
      ovf_in        = ovf_ff;
      dcnt_in       = dcnt_ff;
      npos_in       = npos_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;

      // shared shift-add multiplier runs in these states
      if (state_ff == nbgv_pkg::ST_DEN || state_ff == nbgv_pkg::ST_NUM
          || state_ff == nbgv_pkg::ST_PMUL) begin
         if (mp_ff[0]) acc_in = acc_ff + mc_ff;
         mc_in = {mc_ff[94:0], 1'b0};
         mp_in = {1'b0, mp_ff[47:1]};
      end

      unique case (state_ff)
         nbgv_pkg::ST_IDLE:
            if (req_acc) begin
               kind_in = req_tuser[0];
               last_in = req_tlast;
               ax_in   = '0;
               s_in    = '0;
               tsss_in = ts_ff * ss_ff;
               // other body's mass times dt
               k_in    = req_tdata[223:192] * ts_ff;
               for (int i = 0; i < 3; i++) begin
                  pos_in[i] = own_w[i];
                  neg_in[i] = dif_w[i][32];
                  mg_in[i]  = dif_w[i][32] ? -dif_w[i] : dif_w[i];
               end
               if (req_tuser[0] == nbgv_pkg::KIND_VEL && !req_tuser[1]
                   && (mass_ff == '0 || all_zero)) begin
                  fault_seen_in = 1'b1;
               end
            end
         nbgv_pkg::ST_SHIFT:
            if (big_w) begin
               for (int i = 0; i < 3; i++) mg_in[i] = {1'b0, mg_ff[i][32:1]};
               s_in = s_ff + 4'd1;
            end
         nbgv_pkg::ST_SQ: begin
            r2_in = (ax_ff == 2'd0) ? 42'(sq_w) : r2_ff + 42'(sq_w);
            if (ax_ff == 2'd2) begin
               ax_in  = '0;
               sqn_in = {1'b0, r2_in};
               sqr_in = '0;
               sqb_in = nbgv_pkg::ROOT_TOP;
            end else begin
               ax_in = ax_ff + 2'd1;
            end
         end
         nbgv_pkg::ST_ROOT: begin
            if (sqn_ff >= trial_w) begin
               sqn_in = sqn_ff - trial_w;
               sqr_in = {1'b0, sqr_ff[42:1]} + bitv_w;
            end else begin
               sqr_in = {1'b0, sqr_ff[42:1]};
            end
            sqb_in = sqb_ff - 6'd2;
            if (sqb_ff == '0) begin
               mc_in  = 96'(r2_ff);
               mp_in  = 48'(sqr_in);
               acc_in = '0;
            end
         end
         nbgv_pkg::ST_DEN:
            if (mul_done) dvs_in = 89'(acc_ff[62:0]) << {s_ff, 1'b0};
         nbgv_pkg::ST_NLOAD: begin
            mc_in  = 96'(k_ff);
            mp_in  = 48'(mg25_w);
            acc_in = '0;
         end
         nbgv_pkg::ST_NUM:
            if (mul_done) begin
               num_in  = {acc_ff[80:0], 10'b0};   // times 2^10 of G*256
               rem_in  = '0;
               q_in    = '0;
               ovf_in  = 1'b0;
               dcnt_in = '0;
            end
         nbgv_pkg::ST_DIV: begin
            rem_in  = dge_w ? ddif_w[88:0] : dtry_w[88:0];
            num_in  = {num_ff[89:0], 1'b0};
            q_in    = {q_ff[45:0], dge_w};
            ovf_in  = ovf_ff || (dge_w && (dcnt_ff < 7'(nbgv_pkg::DIV_HI_STEPS)));
            dcnt_in = dcnt_ff + 7'd1;
         end
         nbgv_pkg::ST_ACC: begin
            if (vsum_w[48] != vsum_w[47]) begin
               vel_in[ax_ff] = vsum_w[48] ? nbgv_pkg::VEL_MIN : nbgv_pkg::VEL_MAX;
            end else begin
               vel_in[ax_ff] = vsum_w[47:0];
            end
            ax_in = (ax_ff == 2'd2) ? 2'd0 : ax_ff + 2'd1;
         end
         nbgv_pkg::ST_PLOAD: begin
            mc_in  = 96'(vabs_w);
            mp_in  = tsss_ff;
            acc_in = '0;
         end
         nbgv_pkg::ST_PMUL: ;
         nbgv_pkg::ST_PADD: begin
            if (!pnew_w[34] && pnew_w[33:31] != 3'b000) begin
               npos_in[ax_ff] = 32'h7FFF_FFFF;
            end else if (pnew_w[34] && pnew_w[33:31] != 3'b111) begin
               npos_in[ax_ff] = 32'h8000_0000;
            end else begin
               npos_in[ax_ff] = pnew_w[31:0];
            end
            ax_in = (ax_ff == 2'd2) ? 2'd0 : ax_ff + 2'd1;
         end
         nbgv_pkg::ST_OUT:
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in[143:0] = {vel_ff[2], vel_ff[1], vel_ff[0]};
               rsp_data_in[239:144] = (kind_ff == nbgv_pkg::KIND_POS)
                                      ? {npos_ff[2], npos_ff[1], npos_ff[0]} : 96'b0;
               rsp_user_in = {fault_seen_ff || (mass_ff == '0), kind_ff};
            end
         default: ;
      endcase

      // configuration writes must arrive only while idle; the core itself does not enforce this
      if (csr_we) begin
         unique case (csr_addr)
            nbgv_pkg::CSR_INIT_VEL_X: vel_in[0] = csr_wdata;
            nbgv_pkg::CSR_INIT_VEL_Y: vel_in[1] = csr_wdata;
            nbgv_pkg::CSR_INIT_VEL_Z: vel_in[2] = csr_wdata;
            nbgv_pkg::CSR_TIME_STEP:  ts_in     = csr_wdata[23:0];
            nbgv_pkg::CSR_SPEED:      ss_in     = csr_wdata[23:0];
            nbgv_pkg::CSR_OWN_MASS:   mass_in   = csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= nbgv_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         fault_seen_ff <= 1'b0;
         ts_ff         <= nbgv_pkg::TIME_STEP_RST;
         ss_ff         <= nbgv_pkg::SPEED_RST;
         mass_ff       <= nbgv_pkg::OWN_MASS_RST;
         for (int i = 0; i < 3; i++) vel_ff[i] <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         fault_seen_ff <= fault_seen_in;
         ts_ff         <= ts_in;
         ss_ff         <= ss_in;
         mass_ff       <= mass_in;
         vel_ff        <= vel_in;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff       <= ax_in;
      last_ff     <= last_in;
      kind_ff     <= kind_in;
      pos_ff      <= pos_in;
      mg_ff       <= mg_in;
      neg_ff      <= neg_in;
      s_ff        <= s_in;
      r2_ff       <= r2_in;
      sqn_ff      <= sqn_in;
      sqr_ff      <= sqr_in;
      sqb_ff      <= sqb_in;
      k_ff        <= k_in;
      tsss_ff     <= tsss_in;
      mc_ff       <= mc_in;
      mp_ff       <= mp_in;
      acc_ff      <= acc_in;
      dvs_ff      <= dvs_in;
      rem_ff      <= rem_in;
      num_ff      <= num_in;
      q_ff        <= q_in;
      ovf_ff      <= ovf_in;
      dcnt_ff     <= dcnt_in;
      npos_ff     <= npos_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // divider remainder always stays below a nonzero divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == nbgv_pkg::ST_DIV |-> (dvs_ff != '0) && (rem_ff < dvs_ff))
      else $error("divider remainder out of range");

   // the root handed to the r2*r multiply fits 21 bits
   a_root_width: assert property (@(posedge clock) disable iff (reset)
      state_ff == nbgv_pkg::ST_DEN && $past(state_ff) == nbgv_pkg::ST_ROOT
      |-> mp_ff[47:21] == '0)
      else $error("square root too wide");

   // fault flag is sticky until reset
   a_fault_sticky: assert property (@(posedge clock) disable iff (reset)
      fault_seen_ff |=> fault_seen_ff)
      else $error("fault flag cleared");

endmodule

FILE: tb/nbody_gravity_velocity_step_core_tb.sv
// Testbench for the n-body velocity step core: random and directed stream traffic, scoreboard check.
module nbody_gravity_velocity_step_core_tb;

   typedef struct {
      logic             kind;
      logic             is_self;
      logic             last;
      logic [2:0][31:0] own;
      logic [2:0][31:0] oth;
      logic [31:0]      mass;
   } body_req_type;

   class grav_scoreboard;
      longint      vel[3];
      logic        fault_seen;
      logic [23:0] dt;
      logic [23:0] spd;
      logic [31:0] mass;
      logic [239:0] data_q[$];
      logic [1:0]   user_q[$];
      int          errors;

      function new();
         foreach (vel[i]) vel[i] = 0;
         fault_seen = 1'b0;
         dt = nbgv_pkg::TIME_STEP_RST;
         spd = nbgv_pkg::SPEED_RST;
         mass = nbgv_pkg::OWN_MASS_RST;
         errors = 0;
      endfunction

      function void write_reg(logic [2:0] addr, logic [47:0] wdata);
         case (addr)
            nbgv_pkg::CSR_INIT_VEL_X: vel[0] = longint'($signed(wdata));
            nbgv_pkg::CSR_INIT_VEL_Y: vel[1] = longint'($signed(wdata));
            nbgv_pkg::CSR_INIT_VEL_Z: vel[2] = longint'($signed(wdata));
            nbgv_pkg::CSR_TIME_STEP:  dt = wdata[23:0];
            nbgv_pkg::CSR_SPEED:      spd = wdata[23:0];
            nbgv_pkg::CSR_OWN_MASS:   mass = wdata[31:0];
            default: ;
         endcase
      endfunction

      function logic [63:0] int_sqrt(logic [63:0] n);
         logic [63:0] res;
         logic [63:0] bit_v;
         res = 0;
         bit_v = 64'd1 << 62;
         while (bit_v > n) bit_v = bit_v >> 2;
         while (bit_v != 0) begin
            if (n >= res + bit_v) begin
               n = n - (res + bit_v);
               res = (res >> 1) + bit_v;
            end else begin
               res = res >> 1;
            end
            bit_v = bit_v >> 2;
         end
         return res;
      endfunction

      // one pair of bodies: add dt*G*m*d/|d|^3 to the velocity
      function void add_pull(longint own[3], longint oth[3], logic [31:0] m_other);
         longint       d[3];
         logic [63:0]  mg[3];
         logic [63:0]  a;
         logic [63:0]  r2;
         logic [63:0]  den;
         logic [127:0] k;
         logic [127:0] q;
         logic [63:0]  mag;
         longint       inc;
         longint       sum;
         int           s;
         a = 0;
         r2 = 0;
         s = 0;
         for (int i = 0; i < 3; i++) begin
            d[i] = oth[i] - own[i];
            mg[i] = (d[i] < 0) ? -d[i] : d[i];
            if (mg[i] > a) a = mg[i];
         end
         if (a == 0) begin
            fault_seen = 1'b1;
            return;
         end
         while ((a >> s) >= (64'd1 << 20)) s++;
         for (int i = 0; i < 3; i++) begin
            mg[i] = mg[i] >> s;
            r2 = r2 + mg[i] * mg[i];
         end
         den = r2 * int_sqrt(r2);
         k = m_other;
         k = k * dt;
         for (int i = 0; i < 3; i++) begin
            q = mg[i];
            q = (k * (q * 128'd25600)) / {64'd0, den};
            q = q >> (2 * s);
            mag = (q > 128'h7FFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF : q[63:0];
            inc = (d[i] < 0) ? -longint'(mag) : longint'(mag);
            sum = vel[i] + inc;
            if (sum > 64'sh7FFF_FFFF_FFFF) sum = 64'sh7FFF_FFFF_FFFF;
            if (sum < -64'sh8000_0000_0000) sum = -64'sh8000_0000_0000;
            vel[i] = sum;
         end
      endfunction

      function logic [31:0] step_pos(longint pos, longint v);
         logic [127:0] p;
         logic [63:0]  stp;
         longint       r;
         p = (v < 0) ? -v : v;
         p = p * dt;
         p = p * spd;
         p = p >> 40;
         stp = (p > (128'd1 << 33)) ? (64'd1 << 33) : p[63:0];
         r = (v < 0) ? pos - longint'(stp) : pos + longint'(stp);
         if (r > 64'sd2147483647) r = 64'sd2147483647;
         if (r < -64'sd2147483648) r = -64'sd2147483648;
         return r[31:0];
      endfunction

      function void note_request(body_req_type r);
         longint      own[3];
         longint      oth[3];
         logic [31:0] np[3];
         for (int i = 0; i < 3; i++) begin
            own[i] = longint'($signed(r.own[i]));
            oth[i] = longint'($signed(r.oth[i]));
            np[i] = 32'd0;
         end
         if (r.kind == nbgv_pkg::KIND_VEL) begin
            if (!r.is_self) begin
               if (mass == 0) fault_seen = 1'b1;
               else add_pull(own, oth, r.mass);
            end
            if (!r.last) return;
         end else begin
            for (int i = 0; i < 3; i++) np[i] = step_pos(own[i], vel[i]);
         end
         data_q.push_back({np[2], np[1], np[0],
                           vel[2][47:0], vel[1][47:0], vel[0][47:0]});
         user_q.push_back({fault_seen || (mass == 0), r.kind});
      endfunction

      function void report(string what, logic [63:0] exp_v, logic [63:0] got_v);
         errors++;
         if (errors <= 10)
            $display("mismatch %s: expected %h got %h at %0t", what, exp_v, got_v, $time);
      endfunction

      function void check_result(logic [239:0] data, logic [1:0] user);
         logic [239:0] ed;
         logic [1:0]   eu;
         if (data_q.size() == 0) begin
            report("unexpected result", 0, data[63:0]);
            return;
         end
         ed = data_q.pop_front();
         eu = user_q.pop_front();
         if (data[47:0]    !== ed[47:0])    report("vel_x", ed[47:0], data[47:0]);
         if (data[95:48]   !== ed[95:48])   report("vel_y", ed[95:48], data[95:48]);
         if (data[143:96]  !== ed[143:96])  report("vel_z", ed[143:96], data[143:96]);
         if (data[175:144] !== ed[175:144]) report("new_x", ed[175:144], data[175:144]);
         if (data[207:176] !== ed[207:176]) report("new_y", ed[207:176], data[207:176]);
         if (data[239:208] !== ed[239:208]) report("new_z", ed[239:208], data[239:208]);
         if (user[0] !== eu[0]) report("result_kind", eu[0], user[0]);
         if (user[1] !== eu[1]) report("fault", eu[1], user[1]);
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [223:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [239:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_we = 1'b0;
   logic [2:0]   csr_addr = '0;
   logic [47:0]  csr_wdata = '0;

   grav_scoreboard sb = new();
   bit gaps_on = 1'b1;
   int hold_left = 0;

   nbody_gravity_velocity_step_core u_top (.*);

   always #5 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 4000) - 2000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_offset();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 64) - 32;
         1: return $urandom_range(0, 200000) - 100000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_mass();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
         1: return $urandom_range(1, 100000);
         default: return $urandom;
      endcase
   endfunction

   function automatic body_req_type pair_req(logic self_f, logic last_f);
      body_req_type r;
      r.kind = nbgv_pkg::KIND_VEL;
      r.is_self = self_f;
      r.last = last_f;
      r.mass = pick_mass();
      for (int i = 0; i < 3; i++) begin
         r.own[i] = pick_coord();
         r.oth[i] = r.own[i] + pick_offset();
      end
      return r;
   endfunction

   function automatic body_req_type pos_req();
      body_req_type r;
      r = pair_req($urandom_range(0, 1), $urandom_range(0, 1));
      r.kind = nbgv_pkg::KIND_POS;
      return r;
   endfunction

   task automatic write_csr(logic [2:0] addr, logic [47:0] wdata);
      csr_we = 1'b1;
      csr_addr = addr;
      csr_wdata = wdata;
      @(negedge clock);
      csr_we = 1'b0;
      sb.write_reg(addr, wdata);
   endtask

   task automatic send_req(body_req_type r);
      int g;
      req_tvalid = 1'b1;
      req_tdata = {r.mass, r.oth[2], r.oth[1], r.oth[0], r.own[2], r.own[1], r.own[0]};
      req_tuser = {r.is_self, r.kind};
      req_tlast = r.last;
      do @(posedge clock); while (!req_tready);
      sb.note_request(r);
      @(negedge clock);
      g = gaps_on ? pick_gap() : 0;
      if (g > 0) begin
         req_tvalid = 1'b0;
         repeat (g - 1) @(negedge clock);
      end
   endtask

   // a pass: one to four pairs, the last one flagged, then a position step in two of three passes
   task automatic send_pass();
      int n;
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++)
         send_req(pair_req($urandom_range(0, 7) == 0, i == n - 1));
      if ($urandom_range(0, 2) != 0) send_req(pos_req());
   endtask

   task automatic random_items(int count);
      int sent;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) < 8) begin
            send_pass();
            sent += 3;
         end else begin
            send_req($urandom_range(0, 1) ? pos_req() : pair_req($urandom_range(0, 1),
                                                                 $urandom_range(0, 1)));
            sent++;
         end
      end
   endtask

   // wait until every expected result has come and the core is quiet
   task automatic drain();
      req_tvalid = 1'b0;
      while (sb.data_q.size() != 0) @(negedge clock);
      repeat (500) @(negedge clock);
   endtask

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);

   // result side
   initial begin
      int gap_left;
      gap_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready = 1'b0;
            hold_left--;
         end else if (gap_left > 0) begin
            rsp_tready = 1'b0;
            gap_left--;
         end else begin
            rsp_tready = 1'b1;
            if (gaps_on && $urandom_range(0, 3) == 0) gap_left = pick_gap();
         end
      end
   end

   initial begin
      #100_000_000;
      $display("nbody_gravity_velocity_step_core_tb: done, errors");
      $finish;
   end

   initial begin
      body_req_type r;
      repeat (9) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed: defaults, opposing offsets, self, non-last, position extremes
      r = pair_req(1'b0, 1'b1);
      r.own = '{32'd0, 32'd0, 32'd0};
      r.oth = '{32'd256, 32'd0, 32'd0};
      r.mass = 32'd256;
      send_req(r);
      r.oth = '{32'hFFFF_FF00, 32'h0000_0200, 32'hFFFF_FC00};
      r.mass = 32'hFFFF_FFFF;
      send_req(r);
      r.own = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
      r.oth = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
      send_req(r);
      r.is_self = 1'b1;
      send_req(r);
      r = pair_req(1'b0, 1'b0);
      send_req(r);
      r.last = 1'b1;
      r.mass = 32'd0;
      send_req(r);
      r = pos_req();
      r.own = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0};
      send_req(r);
      drain();

      write_csr(nbgv_pkg::CSR_INIT_VEL_X, 48'h7FFF_FFFF_FFFF);
      write_csr(nbgv_pkg::CSR_INIT_VEL_Y, 48'h8000_0000_0000);
      write_csr(nbgv_pkg::CSR_INIT_VEL_Z, 48'h0000_0001_0000);
      write_csr(nbgv_pkg::CSR_TIME_STEP, 48'hFF_FFFF);
      write_csr(nbgv_pkg::CSR_SPEED, 48'hFF_FFFF);
      write_csr(nbgv_pkg::CSR_OWN_MASS, 48'hFFFF_FFFF);
      write_csr(3'd7, $urandom);
      r = pos_req();
      r.own = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0};
      send_req(r);
      random_items(300);
      // long receiver stall while requests keep coming
      hold_left = 3000;
      random_items(40);
      drain();

      write_csr(nbgv_pkg::CSR_TIME_STEP, 48'd0);
      write_csr(nbgv_pkg::CSR_SPEED, 48'd0);
      write_csr(nbgv_pkg::CSR_OWN_MASS, 48'd1);
      gaps_on = 1'b0;
      random_items(200);
      drain();

      for (int ph = 0; ph < 3; ph++) begin
         write_csr(nbgv_pkg::CSR_INIT_VEL_X, {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF);
         write_csr(nbgv_pkg::CSR_INIT_VEL_Y, $urandom_range(0, 1) ? -48'd70000 : 48'd70000);
         write_csr(nbgv_pkg::CSR_INIT_VEL_Z, {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF);
         write_csr(nbgv_pkg::CSR_TIME_STEP, $urandom_range(1, 24'hFF_FFFF));
         write_csr(nbgv_pkg::CSR_SPEED, $urandom_range(1, 24'hFF_FFFF));
         write_csr(nbgv_pkg::CSR_OWN_MASS, $urandom);
         gaps_on = (ph != 1);
         random_items(320);
         drain();
      end

      // fault cases last: the flag sticks until reset
      gaps_on = 1'b1;
      write_csr(nbgv_pkg::CSR_TIME_STEP, nbgv_pkg::TIME_STEP_RST);
      write_csr(nbgv_pkg::CSR_SPEED, nbgv_pkg::SPEED_RST);
      r = pair_req(1'b0, 1'b1);
      r.oth = r.own;
      send_req(r);
      send_req(pos_req());
      random_items(120);
      drain();
      write_csr(nbgv_pkg::CSR_OWN_MASS, 48'd0);
      r = pair_req(1'b0, 1'b1);
      send_req(r);
      random_items(80);
      drain();

      if (sb.errors == 0 && sb.data_q.size() == 0)
         $display("nbody_gravity_velocity_step_core_tb: done, clean");
      else
         $display("nbody_gravity_velocity_step_core_tb: done, errors");
      $finish;
   end

endmodule

FILE: files.f
rtl/nbgv_pkg.sv
rtl/nbody_gravity_velocity_step_core.sv
tb/nbody_gravity_velocity_step_core_tb.sv
